### hdl/dltq_pkg.sv
package dltq_pkg;

    // Slot count, the widths that follow from it, and the port widths
    localparam int SLOTS   = 8;
    localparam int IDX_W   = $clog2(SLOTS);
    localparam int PTR_W   = $clog2(SLOTS + 1);
    localparam int SLOT_W  = 3;
    localparam int DELTA_W = 32;

    // Null link: one past the last slot
    localparam logic [PTR_W-1:0] NIL_PTR = PTR_W'(SLOTS);

    // Request codes
    localparam logic REQ_ARM  = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UL_WALK,
        ST_UL_ADD,
        ST_INS_START,
        ST_INS_WALK,
        ST_INS_SELF,
        ST_TK_DEC,
        ST_TK_CHK,
        ST_TK_LAST
    } state_t;

endpackage

### hdl/delta_list_timer_queue_top.sv
// Delta-list timer queue over SLOTS slots.
// Input channel (in_valid/in_ready) takes one beat per request: req_type
// REQ_ARM arms or re-arms slot with delay ticks, REQ_TICK advances time by one
// tick. Output channel (out_valid/out_ready) gives one beat per fired slot, in
// deadline order; last marks the final beat of a tick. An arm request gives
// no beat, and a tick that reaches no deadline gives none either.
// Link and delta words sit in two synchronous RAMs with a registered read; a
// sequencer walks the list one entry per cycle through the read port, but a
// tick that fires waits on each beat while the output register is full.
// An arm of a slot already armed first walks to it, unlinks it and adds its
// delta to any successor; every arm then walks to its insertion point. A tick
// counts down the head delta and pops each slot that comes due; in_ready is
// high only while the sequencer is idle.
// A finished beat sits in an output register; a new request is taken while it
// waits, but a stalled receiver holds the sequencer before the next beat.
// Reset (rst_n low) empties the list and clears the armed flags and the
// output valid flag; RAM contents need no clearing since only linked entries
// are ever used.
module delta_list_timer_queue_top
    import dltq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                req_type,
    input  logic [SLOT_W-1:0]   slot,
    input  logic [DELTA_W-1:0]  delay,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [SLOT_W-1:0]   fired_slot,
    output logic                last
);

    state_t               state_reg, state_next;
    logic [PTR_W-1:0]     head_reg, head_next;
    logic [PTR_W-1:0]     cur_reg, cur_next;
    logic [PTR_W-1:0]     prev_reg, prev_next;
    logic [IDX_W-1:0]     slot_reg, slot_next;
    logic [DELTA_W-1:0]   rem_reg, rem_next;
    logic [DELTA_W-1:0]   acc_reg, acc_next;
    logic [IDX_W-1:0]     pend_reg, pend_next;
    logic [SLOTS-1:0]     armed_reg, armed_next;

    logic                 out_valid_reg;
    logic [SLOT_W-1:0]    fired_slot_reg;
    logic                 last_reg;

    // Link and delta RAMs
    logic [PTR_W-1:0]     next_mem  [SLOTS];
    logic [DELTA_W-1:0]   delta_mem [SLOTS];
    logic [PTR_W-1:0]     rd_next;
    logic [DELTA_W-1:0]   rd_delta;
    logic [IDX_W-1:0]     raddr;
    logic                 nw_en;
    logic [IDX_W-1:0]     nw_addr;
    logic [PTR_W-1:0]     nw_data;
    logic                 dw_en;
    logic [IDX_W-1:0]     dw_addr;
    logic [DELTA_W-1:0]   dw_data;

    logic                 emit;
    logic                 emit_last;
    logic                 do_fire;
    logic                 out_free;
    logic [IDX_W-1:0]     cur_idx;
    logic [IDX_W-1:0]     in_idx;
    logic [PTR_W-1:0]     slot_ptr;
    logic [DELTA_W-1:0]   dec_delta;

    assign out_free  = !out_valid_reg || out_ready;
    assign cur_idx   = cur_reg[IDX_W-1:0];
    assign in_idx    = IDX_W'(slot);
    assign slot_ptr  = PTR_W'(slot_reg);
    assign dec_delta = (rd_delta == '0) ? '0 : rd_delta - DELTA_W'(1);

    // RAM write and registered read
    always_ff @(posedge clk)
    begin
        if (nw_en)
        begin
            next_mem[nw_addr] <= nw_data;
        end
        if (dw_en)
        begin
            delta_mem[dw_addr] <= dw_data;
        end
        rd_next  <= next_mem[raddr];
        rd_delta <= delta_mem[raddr];
    end

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= NIL_PTR;
            armed_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            armed_reg <= armed_next;
        end
    end

    // Walk registers
    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        prev_reg <= prev_next;
        slot_reg <= slot_next;
        rem_reg  <= rem_next;
        acc_reg  <= acc_next;
        pend_reg <= pend_next;
    end

    // Next state, RAM accesses and beat emission
    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        cur_next   = cur_reg;
        prev_next  = prev_reg;
        slot_next  = slot_reg;
        rem_next   = rem_reg;
        acc_next   = acc_reg;
        pend_next  = pend_reg;
        armed_next = armed_reg;
        raddr      = cur_idx;
        nw_en      = 1'b0;
        nw_addr    = cur_idx;
        nw_data    = NIL_PTR;
        dw_en      = 1'b0;
        dw_addr    = cur_idx;
        dw_data    = '0;
        emit       = 1'b0;
        emit_last  = 1'b0;
        do_fire    = 1'b0;
        in_ready   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                raddr    = head_reg[IDX_W-1:0];
                if (in_valid)
                begin
                    if (req_type == REQ_TICK)
                    begin
                        if (head_reg != NIL_PTR)
                        begin
                            cur_next   = head_reg;
                            state_next = ST_TK_DEC;
                        end
                    end
                    else if (PTR_W'(slot) < NIL_PTR)
                    begin
                        slot_next = in_idx;
                        rem_next  = delay;
                        prev_next = NIL_PTR;
                        cur_next  = head_reg;
                        state_next = armed_reg[in_idx] ? ST_UL_WALK : ST_INS_START;
                    end
                end
            end

            // Find the slot being re-armed and unlink it
            ST_UL_WALK:
            begin
                if (cur_reg == slot_ptr)
                begin
                    if (prev_reg == NIL_PTR)
                    begin
                        head_next = rd_next;
                    end
                    else
                    begin
                        nw_en   = 1'b1;
                        nw_addr = prev_reg[IDX_W-1:0];
                        nw_data = rd_next;
                    end
                    if (rd_next != NIL_PTR)
                    begin
                        acc_next   = rd_delta;
                        cur_next   = rd_next;
                        raddr      = rd_next[IDX_W-1:0];
                        state_next = ST_UL_ADD;
                    end
                    else
                    begin
                        state_next = ST_INS_START;
                    end
                end
                else if (rd_next == NIL_PTR)
                begin
                    state_next = ST_INS_START;
                end
                else
                begin
                    prev_next = cur_reg;
                    cur_next  = rd_next;
                    raddr     = rd_next[IDX_W-1:0];
                end
            end

            // Hand the removed delta to the successor
            ST_UL_ADD:
            begin
                dw_en      = 1'b1;
                dw_addr    = cur_idx;
                dw_data    = rd_delta + acc_reg;
                state_next = ST_INS_START;
            end

            ST_INS_START:
            begin
                prev_next = NIL_PTR;
                raddr     = head_reg[IDX_W-1:0];
                if (head_reg == NIL_PTR)
                begin
                    head_next           = slot_ptr;
                    armed_next[slot_reg] = 1'b1;
                    cur_next            = NIL_PTR;
                    state_next          = ST_INS_SELF;
                end
                else
                begin
                    cur_next   = head_reg;
                    state_next = ST_INS_WALK;
                end
            end

            // Advance past entries with an earlier deadline
            ST_INS_WALK:
            begin
                if (rem_reg > rd_delta)
                begin
                    rem_next = rem_reg - rd_delta;
                    if (rd_next == NIL_PTR)
                    begin
                        nw_en                = 1'b1;
                        nw_addr              = cur_idx;
                        nw_data              = slot_ptr;
                        armed_next[slot_reg] = 1'b1;
                        cur_next             = NIL_PTR;
                        state_next           = ST_INS_SELF;
                    end
                    else
                    begin
                        prev_next = cur_reg;
                        cur_next  = rd_next;
                        raddr     = rd_next[IDX_W-1:0];
                    end
                end
                else
                begin
                    dw_en   = 1'b1;
                    dw_addr = cur_idx;
                    dw_data = rd_delta - rem_reg;
                    if (prev_reg == NIL_PTR)
                    begin
                        head_next = slot_ptr;
                    end
                    else
                    begin
                        nw_en   = 1'b1;
                        nw_addr = prev_reg[IDX_W-1:0];
                        nw_data = slot_ptr;
                    end
                    armed_next[slot_reg] = 1'b1;
                    state_next           = ST_INS_SELF;
                end
            end

            // Write the new entry itself
            ST_INS_SELF:
            begin
                dw_en      = 1'b1;
                dw_addr    = slot_reg;
                dw_data    = rem_reg;
                nw_en      = 1'b1;
                nw_addr    = slot_reg;
                nw_data    = cur_reg;
                state_next = ST_IDLE;
            end

            // Count down the head delta
            ST_TK_DEC:
            begin
                dw_en   = 1'b1;
                dw_addr = cur_idx;
                dw_data = dec_delta;
                if (dec_delta == '0)
                begin
                    do_fire = 1'b1;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            // Decide whether the pending beat is the last one
            ST_TK_CHK:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (rd_delta == '0)
                    begin
                        do_fire = 1'b1;
                    end
                    else
                    begin
                        emit_last  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_TK_LAST:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    emit_last  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Pop the head slot and look at its successor
        if (do_fire)
        begin
            nw_en               = 1'b1;
            nw_addr             = cur_idx;
            nw_data             = NIL_PTR;
            head_next           = rd_next;
            armed_next[cur_idx] = 1'b0;
            pend_next           = cur_idx;
            if (rd_next == NIL_PTR)
            begin
                state_next = ST_TK_LAST;
            end
            else
            begin
                cur_next   = rd_next;
                raddr      = rd_next[IDX_W-1:0];
                state_next = ST_TK_CHK;
            end
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            fired_slot_reg <= SLOT_W'(pend_reg);
            last_reg       <= emit_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign fired_slot = fired_slot_reg;
    assign last       = last_reg;

endmodule

### hdl/dltq_checker.sv
module dltq_checker
    import dltq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic                req_type,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [SLOT_W-1:0]   fired_slot,
    input  logic                last
);

    // Stalled beat holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(fired_slot) && $stable(last))
        else $error("output beat changed while stalled");

    // A tick burst is not finished while a non-last beat is shown
    a_burst_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> !in_ready)
        else $error("ready raised inside a tick burst");

    // An arm request creates no beat
    a_arm_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (req_type == REQ_ARM) |=> !$rose(out_valid))
        else $error("beat produced by an arm request");

    // Ready drops only on an accepted request
    a_ready_keep: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready && !in_valid |=> in_ready)
        else $error("ready dropped without a request");

endmodule

bind delta_list_timer_queue_top dltq_checker u_dltq_checker (.*);

### tb/tb_delta_list_timer_queue_top.sv
`timescale 1ns / 1ps

module tb_delta_list_timer_queue_top;
    import dltq_pkg::*;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              last;
    } fire_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_MOSTLY
    } rx_mode_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    logic               req_type  = REQ_ARM;
    logic [SLOT_W-1:0]  slot      = '0;
    logic [DELTA_W-1:0] delay     = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [SLOT_W-1:0]  fired_slot;
    logic               last;

    // Shadow timer list
    logic [PTR_W-1:0]   tq_head;
    logic [PTR_W-1:0]   tq_next  [SLOTS];
    logic [DELTA_W-1:0] tq_delta [SLOTS];
    logic               tq_armed [SLOTS];

    // Fired slots still owed by the block, oldest first
    fire_t fire_q[$];

    int       n_arms     = 0;
    int       n_ticks    = 0;
    int       n_fired    = 0;
    int       n_errors   = 0;
    int       burst_left = 0;
    int       rx_cycle   = 0;
    rx_mode_t rx_mode    = RX_OPEN;

    delta_list_timer_queue_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .slot       (slot),
        .delay      (delay),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .fired_slot (fired_slot),
        .last       (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Timer list predictor
    // ------------------------------------------------------------------

    function automatic void clear_timers();
        tq_head = NIL_PTR;
        for (int i = 0; i < SLOTS; i++)
        begin
            tq_next[i]  = NIL_PTR;
            tq_delta[i] = '0;
            tq_armed[i] = 1'b0;
        end
    endfunction

    // Drop a slot from the list; fold its delta into the successor
    function automatic void unlink_timer(input int s);
        int prev;
        int cur;
        int nxt;
        int k;
        prev = SLOTS;
        cur  = tq_head;
        for (k = 0; k < SLOTS && cur < SLOTS && cur != s; k++)
        begin
            prev = cur;
            cur  = tq_next[cur];
        end
        if (k < SLOTS && cur == s)
        begin
            nxt = tq_next[cur];
            if (prev < SLOTS)
                tq_next[prev] = PTR_W'(nxt);
            else
                tq_head = PTR_W'(nxt);
            if (nxt < SLOTS)
                tq_delta[nxt] += tq_delta[cur];
        end
        tq_next[s]  = NIL_PTR;
        tq_delta[s] = '0;
        tq_armed[s] = 1'b0;
    endfunction

    // Place a slot ahead of the first one due at the same time or later
    function automatic void link_timer(input int s, input logic [DELTA_W-1:0] ticks);
        logic [DELTA_W-1:0] rem;
        int prev;
        int cur;
        rem  = ticks;
        prev = SLOTS;
        cur  = tq_head;
        for (int k = 0; k < SLOTS && cur < SLOTS && rem > tq_delta[cur]; k++)
        begin
            rem -= tq_delta[cur];
            prev = cur;
            cur  = tq_next[cur];
        end
        if (cur >= SLOTS)
            cur = SLOTS;
        tq_delta[s] = rem;
        tq_next[s]  = PTR_W'(cur);
        if (cur < SLOTS)
            tq_delta[cur] -= rem;
        if (prev < SLOTS)
            tq_next[prev] = PTR_W'(s);
        else
            tq_head = PTR_W'(s);
        tq_armed[s] = 1'b1;
    endfunction

    // Advance time one tick and queue every slot that comes due
    function automatic void advance_tick();
        fire_t f;
        int    s;
        int    n;
        n = 0;
        if (tq_head < SLOTS)
        begin
            if (tq_delta[tq_head] > 0)
                tq_delta[tq_head] -= 1;
            for (int k = 0; k < SLOTS && tq_head < SLOTS && tq_delta[tq_head] == 0; k++)
            begin
                s            = tq_head;
                tq_head      = tq_next[s];
                tq_next[s]   = NIL_PTR;
                tq_armed[s]  = 1'b0;
                f.slot       = SLOT_W'(s);
                f.last       = 1'b0;
                fire_q.push_back(f);
                n++;
            end
            if (tq_head >= SLOTS)
                tq_head = NIL_PTR;
            if (n > 0)
            begin
                f      = fire_q.pop_back();
                f.last = 1'b1;
                fire_q.push_back(f);
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Send one request beat, with a random gap when the burst runs out
    task automatic send_req(input logic kind, input logic [SLOT_W-1:0] s,
                            input logic [DELTA_W-1:0] d);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
        end
        burst_left--;
        in_valid <= 1'b1;
        req_type <= kind;
        slot     <= s;
        delay    <= d;
        do
            @(posedge clk);
        while (!in_ready);
        if (kind == REQ_TICK)
        begin
            n_ticks++;
            advance_tick();
        end
        else
        begin
            n_arms++;
            if (tq_armed[s])
                unlink_timer(s);
            link_timer(s, d);
        end
    endtask

    task automatic arm(input int s, input logic [DELTA_W-1:0] d);
        send_req(REQ_ARM, SLOT_W'(s), d);
    endtask

    task automatic tick();
        send_req(REQ_TICK, SLOT_W'($urandom), DELTA_W'($urandom));
    endtask

    // Hold off requests until every owed beat has come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (fire_q.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Stall the receiver on its own pattern, switching among four modes at random
    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 128 == 127)
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
        case (rx_mode)
            RX_OPEN:   out_ready <= 1'b1;
            RX_COIN:   out_ready <= ($urandom_range(0, 1) == 0);
            RX_SPARSE: out_ready <= (rx_cycle % 8 == 0);
            default:   out_ready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    task automatic report_error(input string what, input fire_t want, input fire_t got);
        n_errors++;
        if (n_errors <= 10)
            $display("%0t: %s: expected slot %0d last %0d, got slot %0d last %0d",
                     $time, what, want.slot, want.last, got.slot, got.last);
    endtask

    // Check each fired-slot beat against the oldest owed one
    always @(posedge clk)
    begin
        fire_t got;
        fire_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got.slot = fired_slot;
            got.last = last;
            n_fired++;
            if (fire_q.size() == 0)
                report_error("beat with nothing owed", '0, got);
            else
            begin
                want = fire_q.pop_front();
                if (got.slot !== want.slot)
                    report_error("fired_slot mismatch", want, got);
                if (got.last !== want.last)
                    report_error("last mismatch", want, got);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_tick_on_empty();
        tick();
    endtask

    // Zero delay goes to the head and is due on the next tick
    task automatic test_zero_delay();
        arm(3, 32'd0);
        arm(5, 32'd1);
        tick();
        tick();
    endtask

    // Largest delay, then re-arm it short so the unlink path sees it
    task automatic test_extreme_delays();
        arm(7, 32'hFFFF_FFFF);
        arm(0, 32'd0);
        tick();
        arm(7, 32'd1);
        tick();
    endtask

    // Fill every slot; equal deadlines and two ticks that fire two and six beats
    task automatic test_full_fire();
        arm(0, 32'd2);
        arm(1, 32'd1);
        arm(2, 32'd2);
        arm(3, 32'd2);
        arm(4, 32'd1);
        arm(5, 32'd2);
        arm(6, 32'd2);
        arm(7, 32'd2);
        tick();
        tick();
    endtask

    // Re-arm moves a slot ahead of one with the same deadline
    task automatic test_rearm_order();
        arm(1, 32'd2);
        arm(2, 32'd3);
        arm(1, 32'd3);
        tick();
        tick();
        tick();
    endtask

    // Mostly short delays and ticks so slots keep firing; some wide delays
    task automatic test_random_traffic(input int count);
        int pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                tick();
            else if (pick < 85)
                arm($urandom_range(0, SLOTS - 1), DELTA_W'($urandom_range(0, 8)));
            else if (pick < 93)
                arm($urandom_range(0, SLOTS - 1), DELTA_W'($urandom_range(0, 300)));
            else
                arm($urandom_range(0, SLOTS - 1), DELTA_W'($urandom));
            if (i % 140 == 139)
                wait_drained();
        end
    endtask

    initial
    begin
        clear_timers();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_tick_on_empty();
        test_zero_delay();
        test_extreme_delays();
        wait_drained();
        test_full_fire();
        test_rearm_order();
        wait_drained();
        test_random_traffic(420);

        // Let the last beats drain, then allow for the longest arm walk
        in_valid <= 1'b0;
        while (fire_q.size() != 0)
            @(posedge clk);
        repeat (2 * SLOTS + 10) @(posedge clk);

        $display("Covered %0d arm requests and %0d ticks; %0d fired-slot beats checked",
                 n_arms, n_ticks, n_fired);
        $display("under random request gaps and receiver stalls, %0d errors", n_errors);
        if (n_errors == 0)
            $display("tb_delta_list_timer_queue_top: PASS");
        else
            $display("tb_delta_list_timer_queue_top: FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("Timeout with %0d beats still owed", fire_q.size());
        $display("tb_delta_list_timer_queue_top: FAIL");
        $finish;
    end

endmodule
